@@ src/bdsl_pkg.sv @@
// shared types, constants and mapping function of the button debouncer
package bdsl_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_DEBOUNCE_COUNT  = 2'd0;
    localparam logic [1:0] REG_SHIFT_HOLD_TIME = 2'd1;
    localparam logic [1:0] REG_SHIFT_BUTTON    = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] DEBOUNCE_COUNT_RST  = 16'd20;
    localparam logic [15:0] SHIFT_HOLD_TIME_RST = 16'd500;
    localparam logic [6:0]  SHIFT_BUTTON_RST    = 7'd10;

    // item kinds
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // mapping table constants
    localparam logic [6:0] PLAIN_BUTTONS   = 7'd9;
    localparam logic [6:0] ALT_BUTTON      = 7'd9;
    localparam logic [3:0] ALT_LOGICAL     = 4'd5;
    localparam logic [6:0] SHIFTED_BUTTONS = 7'd4;
    localparam logic [6:0] SHIFTED_BASE    = 7'd6;
    localparam logic [3:0] NO_LOGICAL      = 4'd0;

    // per-button entry held in the store
    typedef struct packed {
        logic        stable;
        logic        raw_seen;
        logic [15:0] count;
    } entry_t;

    // status of one entry update
    typedef struct packed {
        logic changed;
        logic stable;
    } upd_t;

    // physical button to logical button, zero means no event
    function automatic logic [3:0] logical_of(input logic [6:0] idx, input logic shifted);
        logic [3:0] lg;
        lg = NO_LOGICAL;
        if (!shifted)
        begin
            if (idx < PLAIN_BUTTONS)
            begin
                lg = 4'(idx + 7'd1);
            end
            else if (idx == ALT_BUTTON)
            begin
                lg = ALT_LOGICAL;
            end
        end
        else if (idx < SHIFTED_BUTTONS)
        begin
            lg = 4'(idx + SHIFTED_BASE);
        end
        return lg;
    endfunction

endpackage

@@ src/bdsl_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module bdsl_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/bdsl_entry_upd.sv @@
// debounce update of one button entry for one raw sample
module bdsl_entry_upd
    import bdsl_pkg::*;
(
    input  entry_t      cur,
    input  logic        raw,
    input  logic [15:0] debounce_count,
    output entry_t      nxt,
    output upd_t        upd
);

    // restart on a raw change, count equal samples, then take the level
    always_comb
    begin
        nxt         = cur;
        upd.changed = 1'b0;
        if (raw != cur.raw_seen)
        begin
            nxt.raw_seen = raw;
            nxt.count    = 16'd0;
        end
        else if (cur.count < debounce_count)
        begin
            nxt.count = cur.count + 16'd1;
        end
        else if (raw != cur.stable)
        begin
            nxt.stable  = raw;
            upd.changed = 1'b1;
        end
        upd.stable = nxt.stable;
    end

endmodule

@@ src/button_debounce_with_shift_layer.sv @@
// top level: multi-button counter debouncer with shift layer
//
// Takes one transaction per clock while in_stall is low: a raw sample of one button or a
// time tick, and gives exactly one result per transaction, which passes through the
// stage 1 register into the output register when the output register is free. The
// per-button state (raw level, sample counter, stable level) sits in one ram that
// is read when a transaction is accepted and written back when it leaves stage 1; a
// bypass register covers a read of the entry written at the same edge, so
// samples of the same button may follow each other every cycle. After reset the
// ram is cleared one entry per cycle, with in_stall high until all entries are cleared;
// configuration writes are taken during that time. The output register lets a new
// transaction in while a result still waits on out_stall.
module button_debounce_with_shift_layer
    import bdsl_pkg::*;
#(
    parameter int NUM_BUTTONS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [6:0]  button_index,
    input  logic        raw_level,
    input  logic [31:0] time_ms,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        event_valid,
    output logic [3:0]  logical_button,
    output logic        event_pressed,
    output logic        shift_on,
    output logic        button_stable
);

    localparam int AW = $clog2(NUM_BUTTONS);
    localparam int EW = $bits(entry_t);

    // configuration registers
    logic [15:0] debounce_count_reg;
    logic [15:0] shift_hold_time_reg;
    logic [6:0]  shift_button_reg;

    // clearing pass
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    // stage 1: transaction waiting for its ram data
    logic          s1_valid_reg;
    logic          s1_action_reg;
    logic          s1_in_range_reg;
    logic [6:0]    s1_idx_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_raw_reg;
    logic [31:0]   s1_time_reg;

    // bypass of the latest write
    logic          byp_valid_reg;
    logic [AW-1:0] byp_addr_reg;
    entry_t        byp_data_reg;

    // shift layer state
    logic        shift_active_reg;
    logic        shift_held_reg;
    logic [31:0] shift_press_time_reg;
    logic [31:0] current_time_reg;
    logic        shift_active_next;
    logic        shift_held_next;
    logic [31:0] shift_press_time_next;
    logic [31:0] current_time_next;

    // output register
    logic       out_valid_reg;
    logic       event_valid_reg;
    logic [3:0] logical_button_reg;
    logic       event_pressed_reg;
    logic       shift_on_reg;
    logic       button_stable_reg;
    logic       event_valid_next;
    logic [3:0] logical_button_next;
    logic       event_pressed_next;
    logic       button_stable_next;

    logic          accept;
    logic          s1_adv;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic [EW-1:0] ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    entry_t        cur_entry;
    entry_t        nxt_entry;
    upd_t          upd;
    logic          s1_sample;
    logic [3:0]    lg;

    // handshake and pipeline advance
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clearing_reg || (s1_valid_reg && !s1_adv);
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(button_index) < NUM_BUTTONS);
    assign in_addr  = AW'(button_index);

    // per-button store
    bdsl_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_BUTTONS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // entry seen by stage 1, with bypass of the latest write
    assign cur_entry = (byp_valid_reg && byp_addr_reg == s1_addr_reg) ? byp_data_reg
                                                                      : entry_t'(ram_rdata);

    bdsl_entry_upd u_upd (
        .cur            (cur_entry),
        .raw            (s1_raw_reg),
        .debounce_count (debounce_count_reg),
        .nxt            (nxt_entry),
        .upd            (upd)
    );

    assign s1_sample = (s1_action_reg == ACT_SAMPLE) && s1_in_range_reg;

    // write back or clear
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_adv && s1_sample;
            ram_waddr = s1_addr_reg;
            ram_wdata = EW'(nxt_entry);
        end
    end

    assign lg = logical_of(s1_idx_reg, shift_active_reg);

    // shift layer and result of the transaction in stage 1
    always_comb
    begin
        shift_active_next     = shift_active_reg;
        shift_held_next       = shift_held_reg;
        shift_press_time_next = shift_press_time_reg;
        current_time_next     = current_time_reg;
        event_valid_next      = 1'b0;
        logical_button_next   = NO_LOGICAL;
        event_pressed_next    = 1'b0;
        button_stable_next    = 1'b0;
        if (s1_action_reg == ACT_TICK)
        begin
            current_time_next = s1_time_reg;
            if (shift_held_reg && !shift_active_reg &&
                (s1_time_reg - shift_press_time_reg) >= 32'(shift_hold_time_reg))
            begin
                shift_active_next = 1'b1;
            end
        end
        else if (s1_in_range_reg)
        begin
            button_stable_next = upd.stable;
            if (upd.changed)
            begin
                if (s1_idx_reg == shift_button_reg)
                begin
                    if (s1_raw_reg)
                    begin
                        shift_held_next       = 1'b1;
                        shift_press_time_next = current_time_reg;
                    end
                    else
                    begin
                        shift_held_next   = 1'b0;
                        shift_active_next = 1'b0;
                    end
                end
                else if (lg != NO_LOGICAL)
                begin
                    event_valid_next    = 1'b1;
                    logical_button_next = lg;
                    event_pressed_next  = s1_raw_reg;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_count_reg  <= DEBOUNCE_COUNT_RST;
            shift_hold_time_reg <= SHIFT_HOLD_TIME_RST;
            shift_button_reg    <= SHIFT_BUTTON_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEBOUNCE_COUNT:  debounce_count_reg  <= cfg_data;
                REG_SHIFT_HOLD_TIME: shift_hold_time_reg <= cfg_data;
                REG_SHIFT_BUTTON:    shift_button_reg    <= cfg_data[6:0];
                default:             ;
            endcase
        end
    end

    // control state: clearing pass, pipeline valids, shift state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg         <= 1'b1;
            clr_addr_reg         <= '0;
            s1_valid_reg         <= 1'b0;
            byp_valid_reg        <= 1'b0;
            out_valid_reg        <= 1'b0;
            shift_active_reg     <= 1'b0;
            shift_held_reg       <= 1'b0;
            shift_press_time_reg <= '0;
            current_time_reg     <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(NUM_BUTTONS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            out_valid_reg <= s1_adv || (out_valid_reg && out_stall);
            if (s1_adv)
            begin
                shift_active_reg     <= shift_active_next;
                shift_held_reg       <= shift_held_next;
                shift_press_time_reg <= shift_press_time_next;
                current_time_reg     <= current_time_next;
                if (s1_sample)
                begin
                    byp_valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg   <= action;
            s1_in_range_reg <= in_range;
            s1_idx_reg      <= button_index;
            s1_addr_reg     <= in_addr;
            s1_raw_reg      <= raw_level;
            s1_time_reg     <= time_ms;
        end
        if (s1_adv && s1_sample)
        begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= nxt_entry;
        end
        if (s1_adv)
        begin
            event_valid_reg    <= event_valid_next;
            logical_button_reg <= logical_button_next;
            event_pressed_reg  <= event_pressed_next;
            shift_on_reg       <= shift_active_next;
            button_stable_reg  <= button_stable_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_valid    = event_valid_reg;
    assign logical_button = logical_button_reg;
    assign event_pressed  = event_pressed_reg;
    assign shift_on       = shift_on_reg;
    assign button_stable  = button_stable_reg;

    // shift can only be active while the shift button is held
    a_active_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        shift_active_reg |-> shift_held_reg)
        else $error("shift active without hold");

    // no transaction enters while the store is being cleared
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !accept)
        else $error("transaction accepted during clearing pass");

    // a reported event carries a real logical button
    a_event_logical: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> (logical_button != NO_LOGICAL))
        else $error("event without logical button");

    // a reported event matches the new stable level
    a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> (event_pressed == button_stable))
        else $error("event level differs from stable level");

endmodule

@@ sim/bdsl_checker.sv @@
// result checker for the button debouncer: tracks per-button state, predicts and compares
module bdsl_checker
    import bdsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        action,
    input  logic [6:0]  button_index,
    input  logic        raw_level,
    input  logic [31:0] time_ms,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        event_valid,
    input  logic [3:0]  logical_button,
    input  logic        event_pressed,
    input  logic        shift_on,
    input  logic        button_stable,
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          events_seen,
    output int          shift_entries
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUTTONS = 128;

    // one result transaction as the block reports it
    typedef struct packed {
        logic       ev;
        logic [3:0] lg;
        logic       pressed;
        logic       shift;
        logic       stab;
    } outcome_t;

    // predicted per-button store
    logic        stable_lvl [BUTTONS];
    logic        raw_lvl    [BUTTONS];
    logic [15:0] run_len    [BUTTONS];

    // predicted shift state and time
    logic        shift_act;
    logic        shift_hold;
    logic [31:0] press_ms;
    logic [31:0] now_ms;

    // predicted register contents
    logic [15:0] deb_cfg;
    logic [15:0] hold_cfg;
    logic [6:0]  shift_cfg;

    outcome_t    outcome_q [$];
    outcome_t    got;
    outcome_t    want;
    int          i;

    // one line per mismatch, counted
    task automatic log_mismatch(input string what, input logic [7:0] seen,
                                input logic [7:0] wanted);
        $display("[%0t] mismatch: %s got %0h expected %0h", $time, what, seen, wanted);
        errors++;
    endtask

    // physical button to logical number, zero when the button gives no event
    function automatic logic [3:0] button_to_logical(input logic [6:0] idx, input logic layer);
        logic [3:0] lg;
        lg = 4'd0;
        if (!layer)
        begin
            if (idx <= 7'd8)
            begin
                lg = 4'(idx) + 4'd1;
            end
            else if (idx == 7'd9)
            begin
                lg = 4'd5;
            end
        end
        else if (idx <= 7'd3)
        begin
            lg = 4'(idx) + 4'd6;
        end
        return lg;
    endfunction

    // apply one input transaction to the predicted state and return its result
    function automatic outcome_t advance(input logic act, input logic [6:0] idx,
                                        input logic raw, input logic [31:0] t);
        outcome_t    r;
        logic [31:0] held_ms;
        r = '0;
        if (act == ACT_TICK)
        begin
            now_ms  = t;
            held_ms = now_ms - press_ms;
            if (shift_hold && !shift_act && held_ms >= {16'd0, hold_cfg})
            begin
                shift_act = 1'b1;
                shift_entries++;
            end
        end
        else
        begin
            if (raw != raw_lvl[idx])
            begin
                raw_lvl[idx] = raw;
                run_len[idx] = 16'd0;
            end
            else if (run_len[idx] < deb_cfg)
            begin
                run_len[idx] = run_len[idx] + 16'd1;
            end
            else if (raw != stable_lvl[idx])
            begin
                stable_lvl[idx] = raw;
                if (idx == shift_cfg)
                begin
                    if (raw)
                    begin
                        shift_hold = 1'b1;
                        press_ms   = now_ms;
                    end
                    else
                    begin
                        shift_hold = 1'b0;
                        shift_act  = 1'b0;
                    end
                end
                else
                begin
                    r.lg = button_to_logical(idx, shift_act);
                    if (r.lg != 4'd0)
                    begin
                        r.ev      = 1'b1;
                        r.pressed = raw;
                        events_seen++;
                    end
                end
            end
            r.stab = stable_lvl[idx];
        end
        r.shift = shift_act;
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < BUTTONS; i++)
            begin
                stable_lvl[i] = 1'b0;
                raw_lvl[i]    = 1'b0;
                run_len[i]    = 16'd0;
            end
            shift_act  = 1'b0;
            shift_hold = 1'b0;
            press_ms   = '0;
            now_ms     = '0;
            deb_cfg    = DEBOUNCE_COUNT_RST;
            hold_cfg   = SHIFT_HOLD_TIME_RST;
            shift_cfg  = SHIFT_BUTTON_RST;
            outcome_q.delete();
        end
        else
        begin
            // result transaction against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got = {event_valid, logical_button, event_pressed, shift_on, button_stable};
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    log_mismatch("result with no transaction waiting", got, 8'd0);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.ev !== want.ev)
                        log_mismatch("event_valid", 8'(got.ev), 8'(want.ev));
                    if (got.lg !== want.lg)
                        log_mismatch("logical_button", 8'(got.lg), 8'(want.lg));
                    if (got.pressed !== want.pressed)
                        log_mismatch("event_pressed", 8'(got.pressed), 8'(want.pressed));
                    if (got.shift !== want.shift)
                        log_mismatch("shift_on", 8'(got.shift), 8'(want.shift));
                    if (got.stab !== want.stab)
                        log_mismatch("button_stable", 8'(got.stab), 8'(want.stab));
                end
            end

            // register writes, unknown indexes dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DEBOUNCE_COUNT:  deb_cfg   = cfg_data;
                    REG_SHIFT_HOLD_TIME: hold_cfg  = cfg_data;
                    REG_SHIFT_BUTTON:    shift_cfg = cfg_data[6:0];
                    default: ;
                endcase
            end

            // input transaction
            if (in_valid && !in_stall)
            begin
                outcome_q.push_back(advance(action, button_index, raw_level, time_ms));
            end
        end
        pending = outcome_q.size();
    end

endmodule

@@ sim/button_debounce_with_shift_layer_tb.sv @@
// testbench top for the button debouncer: stimulus, idling, pressure and verdict
module button_debounce_with_shift_layer_tb;
    import bdsl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // index past the register list, writes there are dropped
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write    = 1'b0;
    logic [1:0]  cfg_index    = REG_DEBOUNCE_COUNT;
    logic [15:0] cfg_data     = 16'd0;
    logic        in_valid     = 1'b0;
    logic        action       = ACT_TICK;
    logic [6:0]  button_index = 7'd0;
    logic        raw_level    = 1'b0;
    logic [31:0] time_ms      = 32'd0;
    logic        out_stall    = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        event_valid;
    logic [3:0]  logical_button;
    logic        event_pressed;
    logic        shift_on;
    logic        button_stable;

    int          chk_errors;
    int          chk_pending;
    int          chk_results;
    int          chk_events;
    int          chk_shift_on;

    // stimulus bookkeeping
    int          items_sent = 0;
    bit          busy       = 1'b0;
    bit          squeeze    = 1'b0;
    bit          hold_done  = 1'b0;
    logic [31:0] clock_ms   = 32'd0;
    logic [15:0] deb_now    = DEBOUNCE_COUNT_RST;
    logic [15:0] hold_now   = SHIFT_HOLD_TIME_RST;
    logic [6:0]  shift_now  = SHIFT_BUTTON_RST;

    button_debounce_with_shift_layer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .button_index   (button_index),
        .raw_level      (raw_level),
        .time_ms        (time_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_valid    (event_valid),
        .logical_button (logical_button),
        .event_pressed  (event_pressed),
        .shift_on       (shift_on),
        .button_stable  (button_stable)
    );

    bdsl_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .button_index   (button_index),
        .raw_level      (raw_level),
        .time_ms        (time_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_valid    (event_valid),
        .logical_button (logical_button),
        .event_pressed  (event_pressed),
        .shift_on       (shift_on),
        .button_stable  (button_stable),
        .errors         (chk_errors),
        .pending        (chk_pending),
        .results_seen   (chk_results),
        .events_seen    (chk_events),
        .shift_entries  (chk_shift_on)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAIL button_debounce_with_shift_layer");
        $finish;
    end

    // offer one input transaction after a random gap and wait until it is taken
    task automatic send_item(input logic act, input logic [6:0] idx, input logic raw,
                             input logic [31:0] t);
        int gap;
        gap = (busy || squeeze) ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        button_index <= idx;
        raw_level    <= raw;
        time_ms      <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // time tick, unused fields random
    task automatic tick_at(input logic [31:0] t);
        clock_ms = t;
        send_item(ACT_TICK, 7'($urandom), 1'($urandom), t);
    endtask

    // raw sample, unused time field random
    task automatic sample(input logic [6:0] idx, input logic raw);
        send_item(ACT_SAMPLE, idx, raw, $urandom);
    endtask

    // bounce, then enough equal samples to move the stable level
    task automatic debounced_change(input logic [6:0] idx, input logic lvl);
        int n;
        n = $urandom_range(0, 3);
        repeat (n) sample(idx, 1'($urandom));
        repeat (int'(deb_now) + 2)
        begin
            sample(idx, lvl);
            if ($urandom_range(0, 4) == 0)
                sample(7'($urandom), 1'($urandom));
        end
    endtask

    // a run one sample short, then the opposite level
    task automatic broken_run(input logic [6:0] idx, input logic lvl);
        repeat (int'(deb_now) + 1) sample(idx, lvl);
        sample(idx, ~lvl);
    endtask

    // mostly mapped buttons and the shift key, sometimes anything
    function automatic logic [6:0] pick_button();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 7'($urandom_range(0, 11));
        if (r < 8)
            return shift_now;
        return 7'($urandom);
    endfunction

    // wait until every result is back and the block is quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (index)
            REG_DEBOUNCE_COUNT:  deb_now   = value;
            REG_SHIFT_HOLD_TIME: hold_now  = value;
            REG_SHIFT_BUTTON:    shift_now = value[6:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] deb, input logic [15:0] hold,
                             input logic [6:0] shift_key);
        drain();
        set_reg(REG_DEBOUNCE_COUNT, deb);
        set_reg(REG_SHIFT_HOLD_TIME, hold);
        set_reg(REG_SHIFT_BUTTON, {9'd0, shift_key});
    endtask

    // random mix of debounced presses, ticks, noise and broken runs
    task automatic run_phase(input logic [15:0] deb, input logic [15:0] hold,
                             input logic [6:0] shift_key, input int n);
        int target;
        int pick;
        configure(deb, hold, shift_key);
        target = items_sent + n;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 29) == 0)
                busy = ~busy;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                debounced_change(pick_button(), 1'($urandom));
            else if (pick < 75)
            begin
                if ($urandom_range(0, 9) == 0)
                    tick_at($urandom);
                else
                    tick_at(clock_ms + $urandom_range(0, 2 * int'(hold_now) + 10));
            end
            else if (pick < 90)
                sample(7'($urandom), 1'($urandom));
            else
                broken_run(pick_button(), 1'($urandom));
        end
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial
    begin
        int w;
        @(posedge clk);
        forever
        begin
            if (!hold_done && items_sent >= 150)
            begin
                hold_done = 1'b1;
                squeeze   = 1'b1;
                out_stall <= 1'b1;
                repeat (80) @(posedge clk);
                squeeze   = 1'b0;
            end
            else
            begin
                w = busy ? 0 : $urandom_range(0, 9);
                if (w != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (w) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one sample of change and one equal sample move the level
        configure(16'd0, 16'd5, 7'd10);
        tick_at(32'd0);
        repeat (2) sample(7'd127, 1'b1);
        repeat (2) sample(7'd9, 1'b1);
        // shift pressed just before the time wraps, turns on exactly at the hold time
        tick_at(32'hFFFF_FFFE);
        repeat (2) sample(7'd10, 1'b1);
        tick_at(32'd1);
        tick_at(32'd3);
        // shift layer events, and a button with no shifted meaning
        repeat (2) sample(7'd0, 1'b1);
        repeat (2) sample(7'd3, 1'b1);
        repeat (2) sample(7'd4, 1'b1);
        // move the shift key while held: the old key no longer clears it
        drain();
        set_reg(REG_SHIFT_BUTTON, 16'd0);
        repeat (2) sample(7'd10, 1'b0);
        repeat (2) sample(7'd0, 1'b0);
        repeat (2) sample(7'd8, 1'b1);
        sample(7'd5, 1'b1);
        sample(7'd5, 1'b0);

        // random phases over several register settings
        run_phase(16'd1, 16'd50, 7'd10, 75);
        run_phase(16'd0, 16'd0, 7'd0, 75);
        run_phase(16'd3, 16'hFFFF, 7'd127, 75);
        run_phase(16'd2, 16'($urandom_range(1, 300)), 7'd3, 75);

        // longest debounce: counters only climb
        configure(16'hFFFF, 16'd100, 7'd10);
        set_reg(REG_SPARE, 16'($urandom));
        repeat (25)
        begin
            if ($urandom_range(0, 2) == 0)
                tick_at(clock_ms + $urandom_range(0, 200));
            else
                sample(pick_button(), 1'($urandom));
        end

        run_phase(16'($urandom_range(0, 4)), 16'($urandom), 7'($urandom), 75);

        // let the last results drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d input transactions, %0d results checked", items_sent,
                 chk_results);
        $display("logical button events %0d, shift layer turned on %0d times", chk_events,
                 chk_shift_on);
        if (chk_errors == 0)
        begin
            $display("PASS button_debounce_with_shift_layer");
        end
        else
        begin
            $display("FAIL button_debounce_with_shift_layer");
        end
        $finish;
    end

endmodule
